// ----- src/bis_pkg.sv -----
// Shared constants for the bilinear image scaler.
package bis_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int WEIGHT_BITS_DEF = 8;

  localparam int COORD_W    = 14;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int SIZE_W     = 11;
  localparam int STEP_W     = 20;
  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = COORD_W + STEP_W;
  localparam int IPOS_W     = POS_W - FRAC_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int LATENCY    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_STEP   = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

endpackage

// ----- src/bilinear_image_scaler_core.sv -----
// Bilinear RGB888 image scaler: banked frame store and six-stage blend pipeline.
//
// Item channel (item_valid/item_ready): func 0 loads one source pixel at
// pixel_row/pixel_col; func 1 asks for the output pixel at pixel_row/pixel_col.
// Loads outside the frame store are dropped. Result channel
// (result_valid/result_ready) carries one pixel per compute, none per load,
// in the order the items were taken.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while no item is in flight.
// A compute passes through stages 1 to 6 in order and shows from the stage 6 register.
// Throughput: one item per clock when not stalled. The frame store is split
// into four banks by row and column parity, each with one read/write port, so the
// four neighbours come out in a single cycle and loads take the same port slot.
// Reset: clears the pipeline valid bits and restores the size and step
// registers; the frame store keeps its contents and must be loaded before use.
// Stall: each stage holds while the one after it is full and stalled; bubbles
// still close up, so item_ready drops only when all six stages hold data.
module bilinear_image_scaler_core #(
  parameter int MAX_WIDTH   = bis_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bis_pkg::MAX_HEIGHT_DEF,
  parameter int WEIGHT_BITS = bis_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic                           func,
  input  logic [bis_pkg::COORD_W-1:0]    pixel_row,
  input  logic [bis_pkg::COORD_W-1:0]    pixel_col,
  input  logic [bis_pkg::CHAN_W-1:0]     in_red,
  input  logic [bis_pkg::CHAN_W-1:0]     in_green,
  input  logic [bis_pkg::CHAN_W-1:0]     in_blue,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [bis_pkg::COORD_W-1:0]    out_row,
  output logic [bis_pkg::COORD_W-1:0]    out_col,
  output logic [bis_pkg::CHAN_W-1:0]     out_red,
  output logic [bis_pkg::CHAN_W-1:0]     out_green,
  output logic [bis_pkg::CHAN_W-1:0]     out_blue,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int HALF_W = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
  localparam int DEPTH  = HALF_W * HALF_H;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WB     = WEIGHT_BITS;
  localparam int WOW    = WB + 1;
  localparam int HBW    = bis_pkg::CHAN_W + WB;
  localparam int VBW    = bis_pkg::CHAN_W + 2 * WB;
  localparam int CW     = bis_pkg::COORD_W;
  localparam int PW     = bis_pkg::PIX_W;
  localparam int CH     = bis_pkg::CHAN_W;
  localparam logic [WOW-1:0] WEIGHT_ONE = WOW'(1) << WB;

  function automatic logic [XW-1:0] last_col(input logic [bis_pkg::SIZE_W-1:0] size);
    if (size == '0) return '0;
    if (32'(size) > MAX_WIDTH) return XW'(MAX_WIDTH - 1);
    return XW'(size - 1'b1);
  endfunction

  function automatic logic [YW-1:0] last_row(input logic [bis_pkg::SIZE_W-1:0] size);
    if (size == '0) return '0;
    if (32'(size) > MAX_HEIGHT) return YW'(MAX_HEIGHT - 1);
    return YW'(size - 1'b1);
  endfunction

  // configuration
  logic [bis_pkg::SIZE_W-1:0] source_width;
  logic [bis_pkg::SIZE_W-1:0] source_height;
  logic [bis_pkg::STEP_W-1:0] horizontal_step;
  logic [bis_pkg::STEP_W-1:0] vertical_step;
  logic [XW-1:0]              col_max;
  logic [YW-1:0]              row_max;

  // stage enables and valids
  logic en1, en2, en3, en4, en5, en6;
  logic v1, v2, v3, v4, v5, v6;

  // stage 1
  logic                     func1;
  logic [CW-1:0]            row1, col1;
  logic [PW-1:0]            pix1;
  logic [bis_pkg::POS_W-1:0] pos_x1, pos_y1;

  // stage 2
  logic            func2, inside2;
  logic [CW-1:0]   row2, col2;
  logic [PW-1:0]   pix2;
  logic [XW-1:0]   x0_2, x1_2;
  logic [YW-1:0]   y0_2, y1_2;
  logic [WB-1:0]   fx2, fy2;
  logic [bis_pkg::IPOS_W-1:0] ip_x, ip_y;

  // stage 3
  logic            func3;
  logic [CW-1:0]   row3, col3;
  logic [PW-1:0]   pix3;
  logic [WB-1:0]   fx3, fy3;
  logic [3:0]      sel3;
  logic [3:0]      we3;
  logic [AW-1:0]   addr3 [4];
  logic [3:0]      we_next;
  logic [AW-1:0]   addr_next [4];
  logic [YW-1:0]   rsel [2];
  logic [XW-1:0]   csel [2];
  logic [YW-1:0]   load_row;
  logic [XW-1:0]   load_col;

  // stage 4
  logic [CW-1:0]   row4, col4;
  logic [WB-1:0]   fx4, fy4;
  logic [3:0]      sel4;
  logic [PW-1:0]   rd4 [4];

  // stage 5
  logic [CW-1:0]   row5, col5;
  logic [WB-1:0]   fy5;
  logic [HBW-1:0]  top5 [3];
  logic [HBW-1:0]  bot5 [3];
  logic [PW-1:0]   pa, pb, pc, pd;
  logic [WOW-1:0]  inv_fx, inv_fy;
  logic [HBW-1:0]  top_next [3];
  logic [HBW-1:0]  bot_next [3];

  // stage 6
  logic [VBW-1:0]  blend [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width    <= bis_pkg::SIZE_RESET;
      source_height   <= bis_pkg::SIZE_RESET;
      horizontal_step <= bis_pkg::STEP_RESET;
      vertical_step   <= bis_pkg::STEP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bis_pkg::REG_SOURCE_WIDTH:    source_width    <= cfg_data[bis_pkg::SIZE_W-1:0];
        bis_pkg::REG_SOURCE_HEIGHT:   source_height   <= cfg_data[bis_pkg::SIZE_W-1:0];
        bis_pkg::REG_HORIZONTAL_STEP: horizontal_step <= cfg_data;
        bis_pkg::REG_VERTICAL_STEP:   vertical_step   <= cfg_data;
      endcase
    end
  end

  // clamped edge indexes, registered from the size registers
  always_ff @(posedge clk) begin
    col_max <= last_col(source_width);
    row_max <= last_row(source_height);
  end

  assign en6        = !v6 || result_ready;
  assign en5        = !v5 || en6;
  assign en4        = !v4 || en5;
  assign en3        = !v3 || en4;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= item_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3 && func3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // stage 1: scale to source position
  always_ff @(posedge clk) begin
    if (en1) begin
      func1  <= func;
      row1   <= pixel_row;
      col1   <= pixel_col;
      pix1   <= {in_red, in_green, in_blue};
      pos_x1 <= bis_pkg::POS_W'(pixel_col) * bis_pkg::POS_W'(horizontal_step);
      pos_y1 <= bis_pkg::POS_W'(pixel_row) * bis_pkg::POS_W'(vertical_step);
    end
  end

  // stage 2: neighbour indexes and weights
  assign ip_x = pos_x1[bis_pkg::POS_W-1:bis_pkg::FRAC_BITS];
  assign ip_y = pos_y1[bis_pkg::POS_W-1:bis_pkg::FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en2) begin
      func2   <= func1;
      row2    <= row1;
      col2    <= col1;
      pix2    <= pix1;
      inside2 <= (32'(row1) < MAX_HEIGHT) && (32'(col1) < MAX_WIDTH);
      fx2     <= pos_x1[bis_pkg::FRAC_BITS-1 -: WB];
      fy2     <= pos_y1[bis_pkg::FRAC_BITS-1 -: WB];
      if (ip_x >= bis_pkg::IPOS_W'(col_max)) begin
        x0_2 <= col_max;
        x1_2 <= col_max;
      end else begin
        x0_2 <= ip_x[XW-1:0];
        x1_2 <= ip_x[XW-1:0] + 1'b1;
      end
      if (ip_y >= bis_pkg::IPOS_W'(row_max)) begin
        y0_2 <= row_max;
        y1_2 <= row_max;
      end else begin
        y0_2 <= ip_y[YW-1:0];
        y1_2 <= ip_y[YW-1:0] + 1'b1;
      end
    end
  end

  // stage 3: bank addresses; bank index is {row parity, column parity}
  assign load_row = row2[YW-1:0];
  assign load_col = col2[XW-1:0];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      rsel[p] = (y0_2[0] == p[0]) ? y0_2 : y1_2;
      csel[p] = (x0_2[0] == p[0]) ? x0_2 : x1_2;
    end
    for (int b = 0; b < 4; b++) begin
      we_next[b] = inside2 && (load_row[0] == b[1]) && (load_col[0] == b[0]);
      if (func2) begin
        addr_next[b] = AW'(32'(rsel[b[1]] >> 1) * HALF_W + 32'(csel[b[0]] >> 1));
      end else begin
        addr_next[b] = AW'(32'(load_row >> 1) * HALF_W + 32'(load_col >> 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      func3 <= func2;
      row3  <= row2;
      col3  <= col2;
      pix3  <= pix2;
      fx3   <= fx2;
      fy3   <= fy2;
      sel3  <= {y1_2[0], y0_2[0], x1_2[0], x0_2[0]};
      we3   <= we_next;
      for (int b = 0; b < 4; b++) begin
        addr3[b] <= addr_next[b];
      end
    end
  end

  // stage 4: frame store banks, loads and reads in item order
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PW-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (en4) begin
        if (v3 && !func3 && we3[b]) begin
          mem[addr3[b]] <= pix3;
        end
        rd4[b] <= mem[addr3[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      row4 <= row3;
      col4 <= col3;
      fx4  <= fx3;
      fy4  <= fy3;
      sel4 <= sel3;
    end
  end

  // stage 5: horizontal blend
  assign pa     = rd4[{sel4[2], sel4[0]}];
  assign pb     = rd4[{sel4[2], sel4[1]}];
  assign pc     = rd4[{sel4[3], sel4[0]}];
  assign pd     = rd4[{sel4[3], sel4[1]}];
  assign inv_fx = WEIGHT_ONE - WOW'(fx4);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      top_next[k] = HBW'(pa[PW-1-CH*k -: CH]) * HBW'(inv_fx) +
                    HBW'(pb[PW-1-CH*k -: CH]) * HBW'(fx4);
      bot_next[k] = HBW'(pc[PW-1-CH*k -: CH]) * HBW'(inv_fx) +
                    HBW'(pd[PW-1-CH*k -: CH]) * HBW'(fx4);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      row5 <= row4;
      col5 <= col4;
      fy5  <= fy4;
      for (int k = 0; k < 3; k++) begin
        top5[k] <= top_next[k];
        bot5[k] <= bot_next[k];
      end
    end
  end

  // stage 6: vertical blend, truncate
  assign inv_fy = WEIGHT_ONE - WOW'(fy5);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      blend[k] = VBW'(top5[k]) * VBW'(inv_fy) + VBW'(bot5[k]) * VBW'(fy5);
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      out_row   <= row5;
      out_col   <= col5;
      out_red   <= blend[0][VBW-1 -: CH];
      out_green <= blend[1][VBW-1 -: CH];
      out_blue  <= blend[2][VBW-1 -: CH];
    end
  end

  assign result_valid = v6;

endmodule

// ----- src/bis_checker.sv -----
// Port-level assertions for the bilinear image scaler, bound to the top level.
module bis_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [bis_pkg::COORD_W-1:0]    out_row,
  input logic [bis_pkg::COORD_W-1:0]    out_col,
  input logic [bis_pkg::CHAN_W-1:0]     out_red,
  input logic [bis_pkg::CHAN_W-1:0]     out_green,
  input logic [bis_pkg::CHAN_W-1:0]     out_blue
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (result_valid && !result_ready))
    else $error("item_ready low without a stalled result");

  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item_ready low with no result waiting");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(out_row) &&
      $stable(out_col) && $stable(out_red) && $stable(out_green) && $stable(out_blue)))
    else $error("stalled result changed");

endmodule

bind bilinear_image_scaler_core bis_checker u_bis_checker (.*);

// ----- bench/bilinear_image_scaler_core_tb.sv -----
// Self-checking testbench for the bilinear image scaler core with a pixel scoreboard.
package scaler_tb_pkg;

  localparam int unsigned STORE_W  = bis_pkg::MAX_WIDTH_DEF;
  localparam int unsigned STORE_H  = bis_pkg::MAX_HEIGHT_DEF;
  localparam int unsigned WGT_BITS = bis_pkg::WEIGHT_BITS_DEF;
  localparam int unsigned WGT_ONE  = 1 << WGT_BITS;

  typedef enum logic {FUNC_LOAD = 1'b0, FUNC_COMPUTE = 1'b1} scaler_func_t;

  typedef struct packed {
    scaler_func_t                func;
    logic [bis_pkg::COORD_W-1:0] row;
    logic [bis_pkg::COORD_W-1:0] col;
    logic [bis_pkg::CHAN_W-1:0]  red;
    logic [bis_pkg::CHAN_W-1:0]  green;
    logic [bis_pkg::CHAN_W-1:0]  blue;
  } scaler_item_t;

  typedef struct packed {
    logic [bis_pkg::COORD_W-1:0] row;
    logic [bis_pkg::COORD_W-1:0] col;
    logic [bis_pkg::CHAN_W-1:0]  red;
    logic [bis_pkg::CHAN_W-1:0]  green;
    logic [bis_pkg::CHAN_W-1:0]  blue;
  } scaler_pixel_t;

  class pixel_scoreboard;
    bit [bis_pkg::PIX_W-1:0]  pixels [int];
    bit [bis_pkg::SIZE_W-1:0] width_reg  = bis_pkg::SIZE_RESET;
    bit [bis_pkg::SIZE_W-1:0] height_reg = bis_pkg::SIZE_RESET;
    bit [bis_pkg::STEP_W-1:0] hstep_reg  = bis_pkg::STEP_RESET;
    bit [bis_pkg::STEP_W-1:0] vstep_reg  = bis_pkg::STEP_RESET;
    scaler_pixel_t            pending_pixels [$];
    int                       errors;

    function int pixel_key(int unsigned r, int unsigned c);
      return int'(r * STORE_W + c);
    endfunction

    function int unsigned effective_size(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void write_reg(logic [bis_pkg::CFG_IDX_W-1:0] index,
                            logic [bis_pkg::CFG_DATA_W-1:0] data);
      case (index)
        bis_pkg::REG_SOURCE_WIDTH:    width_reg  = data[bis_pkg::SIZE_W-1:0];
        bis_pkg::REG_SOURCE_HEIGHT:   height_reg = data[bis_pkg::SIZE_W-1:0];
        bis_pkg::REG_HORIZONTAL_STEP: hstep_reg  = data[bis_pkg::STEP_W-1:0];
        bis_pkg::REG_VERTICAL_STEP:   vstep_reg  = data[bis_pkg::STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // neighbour pair along one axis, clamped to the source edge, plus blend weight
    function void locate(input logic [bis_pkg::COORD_W-1:0] coord,
                         input logic [bis_pkg::STEP_W-1:0] step,
                         input int unsigned size, output int unsigned lo,
                         output int unsigned hi, output int unsigned weight);
      longint unsigned pos;
      longint unsigned ipos;
      pos = coord;
      pos = pos * step;
      ipos = pos >> bis_pkg::FRAC_BITS;
      weight = int'((pos >> (bis_pkg::FRAC_BITS - WGT_BITS)) & (WGT_ONE - 1));
      if (ipos >= size - 1) begin
        lo = size - 1;
        hi = size - 1;
      end else begin
        lo = int'(ipos);
        hi = int'(ipos) + 1;
      end
    endfunction

    function bit neighbours_loaded(logic [bis_pkg::COORD_W-1:0] row,
                                   logic [bis_pkg::COORD_W-1:0] col);
      int unsigned x0, x1, y0, y1, fx, fy;
      locate(col, hstep_reg, effective_size(width_reg, STORE_W), x0, x1, fx);
      locate(row, vstep_reg, effective_size(height_reg, STORE_H), y0, y1, fy);
      return pixels.exists(pixel_key(y0, x0)) && pixels.exists(pixel_key(y0, x1)) &&
             pixels.exists(pixel_key(y1, x0)) && pixels.exists(pixel_key(y1, x1));
    endfunction

    function void note_item(scaler_item_t it);
      int unsigned x0, x1, y0, y1, fx, fy;
      int unsigned a, b, c, d, top, bot, v;
      bit [bis_pkg::PIX_W-1:0] pa, pb, pc, pd;
      bit [bis_pkg::CHAN_W-1:0] chan [3];
      scaler_pixel_t px;
      if (it.func == FUNC_LOAD) begin
        if (it.row < STORE_H && it.col < STORE_W)
          pixels[pixel_key(it.row, it.col)] = {it.red, it.green, it.blue};
        return;
      end
      locate(it.col, hstep_reg, effective_size(width_reg, STORE_W), x0, x1, fx);
      locate(it.row, vstep_reg, effective_size(height_reg, STORE_H), y0, y1, fy);
      pa = pixels[pixel_key(y0, x0)];
      pb = pixels[pixel_key(y0, x1)];
      pc = pixels[pixel_key(y1, x0)];
      pd = pixels[pixel_key(y1, x1)];
      for (int k = 0; k < 3; k++) begin
        a = (pa >> (16 - 8 * k)) & 8'hFF;
        b = (pb >> (16 - 8 * k)) & 8'hFF;
        c = (pc >> (16 - 8 * k)) & 8'hFF;
        d = (pd >> (16 - 8 * k)) & 8'hFF;
        top = a * (WGT_ONE - fx) + b * fx;
        bot = c * (WGT_ONE - fx) + d * fx;
        v = top * (WGT_ONE - fy) + bot * fy;
        chan[k] = 8'(v >> (2 * WGT_BITS));
      end
      px.row   = it.row;
      px.col   = it.col;
      px.red   = chan[0];
      px.green = chan[1];
      px.blue  = chan[2];
      pending_pixels.push_back(px);
    endfunction

    function void compare_field(string name, int unsigned want,
                                logic [bis_pkg::COORD_W-1:0] got);
      if (got !== bis_pkg::COORD_W'(want)) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(scaler_pixel_t got);
      scaler_pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result transfer: row %0d col %0d", got.row, got.col);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("out_row", want.row, got.row);
      compare_field("out_col", want.col, got.col);
      compare_field("out_red", want.red, got.red);
      compare_field("out_green", want.green, got.green);
      compare_field("out_blue", want.blue, got.blue);
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass
endpackage

module bilinear_image_scaler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             item_valid = 1'b0;
  logic                             item_ready;
  logic                             func = 1'b0;
  logic [bis_pkg::COORD_W-1:0]      pixel_row = '0;
  logic [bis_pkg::COORD_W-1:0]      pixel_col = '0;
  logic [bis_pkg::CHAN_W-1:0]       in_red = '0;
  logic [bis_pkg::CHAN_W-1:0]       in_green = '0;
  logic [bis_pkg::CHAN_W-1:0]       in_blue = '0;
  logic                             result_valid;
  logic                             result_ready = 1'b0;
  logic [bis_pkg::COORD_W-1:0]      out_row;
  logic [bis_pkg::COORD_W-1:0]      out_col;
  logic [bis_pkg::CHAN_W-1:0]       out_red;
  logic [bis_pkg::CHAN_W-1:0]       out_green;
  logic [bis_pkg::CHAN_W-1:0]       out_blue;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [bis_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  scaler_tb_pkg::pixel_scoreboard sb;
  scaler_tb_pkg::scaler_pixel_t   seen_pixel;
  bit                             steady;
  bit                             hold_request;
  bit                             hold_done;
  int                             hold_left;
  int                             stall_cycles;

  bilinear_image_scaler_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .func(func),
    .pixel_row(pixel_row), .pixel_col(pixel_col),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .result_valid(result_valid), .result_ready(result_ready),
    .out_row(out_row), .out_col(out_col),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // result side: check each transfer, random backpressure, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        seen_pixel = {out_row, out_col, out_red, out_green, out_blue};
        sb.check_pixel(seen_pixel);
      end
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= steady || ($urandom_range(99) >= 26);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic offer_item(input scaler_tb_pkg::scaler_item_t it);
    item_valid <= 1'b1;
    func       <= it.func;
    pixel_row  <= it.row;
    pixel_col  <= it.col;
    in_red     <= it.red;
    in_green   <= it.green;
    in_blue    <= it.blue;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
    while (!steady && $urandom_range(99) < 26) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic load_rgb(input int unsigned r, input int unsigned c, input logic [23:0] rgb);
    scaler_tb_pkg::scaler_item_t it;
    it.func = scaler_tb_pkg::FUNC_LOAD;
    it.row  = r[bis_pkg::COORD_W-1:0];
    it.col  = c[bis_pkg::COORD_W-1:0];
    {it.red, it.green, it.blue} = rgb;
    offer_item(it);
  endtask

  task automatic request_pixel(input int unsigned r, input int unsigned c);
    scaler_tb_pkg::scaler_item_t it;
    it.func  = scaler_tb_pkg::FUNC_COMPUTE;
    it.row   = r[bis_pkg::COORD_W-1:0];
    it.col   = c[bis_pkg::COORD_W-1:0];
    it.red   = 8'($urandom_range(255));
    it.green = 8'($urandom_range(255));
    it.blue  = 8'($urandom_range(255));
    offer_item(it);
  endtask

  function automatic int unsigned pick_coord();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 16383;
      2, 3:    return $urandom_range(16383);
      4, 5, 6: return $urandom_range(7);
      default: return $urandom_range(63);
    endcase
  endfunction

  // never touch an unwritten store entry; the far corner is always loaded
  task automatic request_random_pixel();
    int unsigned r, c;
    r = 16383;
    c = 16383;
    for (int tries = 0; tries < 64; tries++) begin
      r = pick_coord();
      c = pick_coord();
      if (sb.neighbours_loaded(r[bis_pkg::COORD_W-1:0], c[bis_pkg::COORD_W-1:0])) break;
      r = 16383;
      c = 16383;
    end
    request_pixel(r, c);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (bis_pkg::LATENCY + 2) @(posedge clk);
  endtask

  task automatic configure(input logic [bis_pkg::SIZE_W-1:0] w,
                           input logic [bis_pkg::SIZE_W-1:0] h,
                           input logic [bis_pkg::STEP_W-1:0] hs,
                           input logic [bis_pkg::STEP_W-1:0] vs);
    logic [bis_pkg::CFG_IDX_W-1:0]  idx [4];
    logic [bis_pkg::CFG_DATA_W-1:0] val [4];
    logic [8:0]                     junk_w, junk_h;
    junk_w = 9'($urandom_range(511));
    junk_h = 9'($urandom_range(511));
    idx[0] = bis_pkg::REG_SOURCE_WIDTH;    val[0] = {junk_w, w};
    idx[1] = bis_pkg::REG_SOURCE_HEIGHT;   val[1] = {junk_h, h};
    idx[2] = bis_pkg::REG_HORIZONTAL_STEP; val[2] = hs;
    idx[3] = bis_pkg::REG_VERTICAL_STEP;   val[3] = vs;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // rows or columns to preload: all of a small axis, else both ends and a random pair
  function automatic void plan_axis(input int unsigned size, ref int unsigned pts[$]);
    int unsigned m;
    pts.delete();
    if (size <= 10) begin
      for (int unsigned i = 0; i < size; i++) pts.push_back(i);
    end else begin
      m = $urandom_range(4, size - 4);
      pts = '{0, 1, 2, 3, m, m + 1, size - 2, size - 1};
    end
  endfunction

  task automatic run_phase(input logic [bis_pkg::SIZE_W-1:0] w,
                           input logic [bis_pkg::SIZE_W-1:0] h,
                           input logic [bis_pkg::STEP_W-1:0] hs,
                           input logic [bis_pkg::STEP_W-1:0] vs,
                           input int count, input bit pressure);
    int unsigned rows[$], cols[$];
    int unsigned r, c, sel;
    int          done;
    bit          paused;
    settle();
    configure(w, h, hs, vs);
    plan_axis(sb.effective_size(w, scaler_tb_pkg::STORE_W), cols);
    plan_axis(sb.effective_size(h, scaler_tb_pkg::STORE_H), rows);
    foreach (rows[i])
      foreach (cols[j])
        load_rgb(rows[i], cols[j], 24'($urandom_range(24'hFFFFFF)));
    done = 0;
    paused = 1'b0;
    while (done < count) begin
      if (pressure && done == 20) hold_request = 1'b1;
      if (pressure && done == count / 2 && !paused) begin
        drain_results();
        paused = 1'b1;
      end
      sel = $urandom_range(99);
      if (sel < 65) begin
        request_random_pixel();
        done++;
      end else if (sel < 85) begin
        load_rgb(rows[$urandom_range(rows.size() - 1)], cols[$urandom_range(cols.size() - 1)],
                 24'($urandom_range(24'hFFFFFF)));
        done++;
      end else begin
        if ($urandom_range(1)) begin
          r = $urandom_range(16383);
          c = $urandom_range(16383);
        end else begin
          r = $urandom_range(scaler_tb_pkg::STORE_H - 1);
          c = $urandom_range(scaler_tb_pkg::STORE_W - 1);
        end
        if (r < scaler_tb_pkg::STORE_H && c < scaler_tb_pkg::STORE_W) done++;
        load_rgb(r, c, 24'($urandom_range(24'hFFFFFF)));
      end
    end
  endtask

  // reset configuration: corners, edge clamping, dropped loads
  task automatic run_directed();
    load_rgb(0, 0, 24'hFFFFFF);
    load_rgb(0, 1, 24'h000000);
    load_rgb(1, 0, 24'hFF00FF);
    load_rgb(1, 1, 24'h00FF00);
    load_rgb(1, 2, 24'h3C5A78);
    load_rgb(2, 1, 24'h9E0D44);
    load_rgb(2, 2, 24'h61B2F0);
    load_rgb(1022, 1022, 24'h123456);
    load_rgb(1022, 1023, 24'h80FF01);
    load_rgb(1023, 1022, 24'h7F00FE);
    load_rgb(1023, 1023, 24'hA5C35A);
    load_rgb(0, 1023, 24'hFEDCBA);
    load_rgb(1, 1023, 24'h010203);
    load_rgb(1023, 0, 24'hC0FFEE);
    load_rgb(1023, 1, 24'h55AA55);
    load_rgb(1024, 0, 24'h0F0F0F);
    load_rgb(0, 1024, 24'hF0F0F0);
    load_rgb(16383, 16383, 24'hFFFFFF);
    request_pixel(0, 0);
    request_pixel(1, 1);
    request_pixel(0, 16383);
    request_pixel(16383, 0);
    request_pixel(16383, 16383);
    request_pixel(1022, 1022);
    request_pixel(1023, 1023);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_phase(11'd1024, 11'd1024, 20'h10000, 20'h10000, 80, 1'b0);
    run_phase(11'd8, 11'd6, 20'h0C000, 20'h0AAAB, 100, 1'b0);
    run_phase(11'd5, 11'd7, 20'h23456, 20'h18000, 100, 1'b0);
    run_phase(11'd0, 11'd0, 20'h00000, 20'h00000, 50, 1'b0);
    run_phase(11'd2047, 11'd3, 20'hFFFFF, 20'h01000, 80, 1'b0);
    run_phase(11'd1024, 11'd1024, 20'h01000, 20'h01000, 80, 1'b0);
    steady = 1'b1;
    run_phase(11'd2, 11'd2, 20'h08000, 20'h08000, 80, 1'b0);
    steady = 1'b0;
    run_phase(11'd10, 11'd9, 20'($urandom_range(20'hFFFFF)),
              20'($urandom_range(20'hFFFFF)), 200, 1'b1);
    run_phase(11'd1, 11'd1024, 20'($urandom_range(20'hFFFFF)), 20'h10000, 80, 1'b0);
    run_phase(11'($urandom_range(1, 16)), 11'($urandom_range(1, 16)),
              20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)), 120, 1'b0);
    settle();
    repeat (2 * bis_pkg::LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- bilinear_image_scaler_core.f -----
src/bis_pkg.sv
src/bilinear_image_scaler_core.sv
src/bis_checker.sv
bench/bilinear_image_scaler_core_tb.sv
